>>> rtl/core/lpgf_pkg.sv
// ----------------------------------------------------------------------------
// lpgf_pkg
// Shared constants for the lidar point gate filter: defaults, register
// indexes, reset values and tag quality codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpgf_pkg;

    localparam int COORD_BITS_DEF      = 24;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    localparam int DEC_BITS       = 8;
    localparam int RANGE_BITS     = 20;
    localparam int RANGE_SQ_BITS  = 2 * RANGE_BITS;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 20;
    localparam int BYTE_BITS      = 8;
    localparam int OFFS_BITS      = 32;
    localparam int SPAN_BITS      = 32;
    localparam int ABS_BITS       = 63;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DECIMATION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLIND_MM   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_MM     = 2'd2;

    localparam logic [DEC_BITS-1:0]   DEC_RESET   = 8'd1;
    localparam logic [RANGE_BITS-1:0] BLIND_RESET = 20'd0;
    localparam logic [RANGE_BITS-1:0] MAX_RESET   = 20'd150000;

    localparam logic [BYTE_BITS-1:0] TAG_QUAL_MASK = 8'h30;
    localparam logic [BYTE_BITS-1:0] TAG_QUAL_HIGH = 8'h10;
    localparam logic [BYTE_BITS-1:0] TAG_QUAL_NONE = 8'h00;

    typedef struct packed {
        logic [DEC_BITS-1:0]   decimation;
        logic [RANGE_BITS-1:0] blind_mm;
        logic [RANGE_BITS-1:0] max_range_mm;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/core/lpgf_front.sv
// ----------------------------------------------------------------------------
// lpgf_front
// Accepts points, tracks the frame phase, squares the coordinates and
// pushes points that pass every gate into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpgf_front #(
    parameter int COORD_BITS = lpgf_pkg::COORD_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire lpgf_pkg::t_cfg                    i_cfg,
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire                                    i_first,
    input  wire                                    i_finite,
    input  wire signed [COORD_BITS-1:0]            i_x,
    input  wire signed [COORD_BITS-1:0]            i_y,
    input  wire signed [COORD_BITS-1:0]            i_z,
    input  wire        [lpgf_pkg::BYTE_BITS-1:0]   i_refl,
    input  wire        [lpgf_pkg::BYTE_BITS-1:0]   i_line,
    input  wire        [lpgf_pkg::BYTE_BITS-1:0]   i_tag,
    input  wire        [lpgf_pkg::OFFS_BITS-1:0]   i_offs,
    input  wire        [lpgf_pkg::SPAN_BITS-1:0]   i_span,
    input  wire        [lpgf_pkg::ABS_BITS-1:0]    i_start,
    output logic                                   o_push,
    input  wire                                    i_q_ready,
    output logic [3*COORD_BITS+2*lpgf_pkg::BYTE_BITS+lpgf_pkg::OFFS_BITS
                  +lpgf_pkg::SPAN_BITS+lpgf_pkg::ABS_BITS-1:0] o_payload
);
    import lpgf_pkg::*;

    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int SUM_BITS = SQ_BITS + 2;
    localparam int CMP_BITS = (SUM_BITS > RANGE_SQ_BITS) ? SUM_BITS : RANGE_SQ_BITS;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SQR  = 3'b010,
        F_CHK  = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;

    logic [DEC_BITS-1:0]          r_phase, n_phase;
    logic                         r_pre;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic [BYTE_BITS-1:0]         r_refl, r_line;
    logic [OFFS_BITS-1:0]         r_offs;
    logic [SPAN_BITS-1:0]         r_span;
    logic [ABS_BITS-1:0]          r_start;
    logic [SQ_BITS-1:0]           r_sqx, r_sqy, r_sqz;
    logic [RANGE_SQ_BITS-1:0]     r_bl2, r_mx2;

    logic [DEC_BITS-1:0]   dec_eff;
    logic [DEC_BITS-1:0]   phase_cur;
    logic [DEC_BITS:0]     phase_inc;
    logic                  tag_ok;
    logic [COORD_BITS-1:0] mag_x, mag_y, mag_z;
    logic [SUM_BITS-1:0]   r2;
    logic [CMP_BITS-1:0]   r2_cmp, bl2_cmp, mx2_cmp;
    logic                  pass;

    always_comb begin
        dec_eff   = (i_cfg.decimation == '0) ? DEC_BITS'(1) : i_cfg.decimation;
        phase_cur = i_first ? '0 : r_phase;
        phase_inc = {1'b0, phase_cur} + (DEC_BITS+1)'(1);
        n_phase   = (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DEC_BITS-1:0];
        tag_ok    = ((i_tag & TAG_QUAL_MASK) == TAG_QUAL_HIGH) ||
                    ((i_tag & TAG_QUAL_MASK) == TAG_QUAL_NONE);
    end

    // magnitudes; the most negative code maps onto its own bits as unsigned
    always_comb begin
        mag_x = r_x[COORD_BITS-1] ? (~r_x + COORD_BITS'(1)) : r_x;
        mag_y = r_y[COORD_BITS-1] ? (~r_y + COORD_BITS'(1)) : r_y;
        mag_z = r_z[COORD_BITS-1] ? (~r_z + COORD_BITS'(1)) : r_z;
    end

    always_comb begin
        r2      = SUM_BITS'(r_sqx) + SUM_BITS'(r_sqy) + SUM_BITS'(r_sqz);
        r2_cmp  = CMP_BITS'(r2);
        bl2_cmp = CMP_BITS'(r_bl2);
        mx2_cmp = CMP_BITS'(r_mx2);
        pass    = r_pre && (r2_cmp <= mx2_cmp) && (r2_cmp >= bl2_cmp);
    end

    assign o_ready   = (r_state == F_IDLE);
    assign o_push    = (r_state == F_CHK) && pass;
    assign o_payload = {r_start, r_span, r_offs, r_line, r_refl, r_z, r_y, r_x};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_SQR;
                end
            end
            F_SQR: begin
                n_state = F_CHK;
            end
            F_CHK: begin
                // hold a passing point until the queue has room
                if (!pass || i_q_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            if (i_valid && o_ready) begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bl2 <= i_cfg.blind_mm * i_cfg.blind_mm;
        r_mx2 <= i_cfg.max_range_mm * i_cfg.max_range_mm;
        if (i_valid && o_ready) begin
            r_pre   <= i_finite && (phase_cur == '0) && tag_ok;
            r_x     <= i_x;
            r_y     <= i_y;
            r_z     <= i_z;
            r_refl  <= i_refl;
            r_line  <= i_line;
            r_offs  <= i_offs;
            r_span  <= i_span;
            r_start <= i_start;
        end
        if (r_state == F_SQR) begin
            r_sqx <= mag_x * mag_x;
            r_sqy <= mag_y * mag_y;
            r_sqz <= mag_z * mag_z;
        end
    end

    a_push_in_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state == F_CHK))
        else $error("front push outside check state");

    a_accept_to_sqr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == F_SQR))
        else $error("front accept did not start squaring");

    a_sqr_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_SQR) |=> (r_state == F_CHK))
        else $error("front squaring did not reach check");

endmodule

`default_nettype wire

>>> rtl/core/lpgf_queue.sv
// ----------------------------------------------------------------------------
// lpgf_queue
// Short request queue between the gating front and the timing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpgf_queue #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_ready,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data
);
    import lpgf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lpgf_back.sv
// ----------------------------------------------------------------------------
// lpgf_back
// Takes passed points from the queue, forms absolute time and alpha with
// a one-bit-per-cycle divider, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpgf_back #(
    parameter int COORD_BITS      = lpgf_pkg::COORD_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = lpgf_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_q_valid,
    output logic o_pop,
    input  wire  [3*COORD_BITS+2*lpgf_pkg::BYTE_BITS+lpgf_pkg::OFFS_BITS
                  +lpgf_pkg::SPAN_BITS+lpgf_pkg::ABS_BITS-1:0] i_payload,
    output logic o_valid,
    input  wire  i_ready,
    // x, y, z, intensity, ring, relative_ns, absolute_ns, frame_span_ns, alpha
    output logic [3*COORD_BITS+2*lpgf_pkg::BYTE_BITS+lpgf_pkg::OFFS_BITS
                  +lpgf_pkg::ABS_BITS+lpgf_pkg::SPAN_BITS+ALPHA_FRAC_BITS:0] o_data
);
    import lpgf_pkg::*;

    localparam int AW    = ALPHA_FRAC_BITS + 1;
    localparam int CNT_W = $clog2(ALPHA_FRAC_BITS + 1);
    localparam int HEAD  = 3 * COORD_BITS + 2 * BYTE_BITS;
    localparam int OUT_W = HEAD + OFFS_BITS + ABS_BITS + SPAN_BITS + AW;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    logic [HEAD-1:0]            r_head;
    logic [OFFS_BITS-1:0]       r_offs;
    logic [SPAN_BITS-1:0]       r_span;
    logic [ABS_BITS-1:0]        r_abs;
    logic [SPAN_BITS-1:0]       r_rem;
    logic [ALPHA_FRAC_BITS-1:0] r_quo;
    logic                       r_sat;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out;

    logic [HEAD-1:0]      p_head;
    logic [OFFS_BITS-1:0] p_offs;
    logic [SPAN_BITS-1:0] p_span;
    logic [ABS_BITS-1:0]  p_start;
    logic [ABS_BITS:0]    abs_sum;
    logic [SPAN_BITS:0]   rem2;
    logic                 rem_ge;
    logic [AW-1:0]        alpha;
    logic                 load_out;

    assign p_head  = i_payload[HEAD-1:0];
    assign p_offs  = i_payload[HEAD +: OFFS_BITS];
    assign p_span  = i_payload[HEAD+OFFS_BITS +: SPAN_BITS];
    assign p_start = i_payload[HEAD+OFFS_BITS+SPAN_BITS +: ABS_BITS];
    assign abs_sum = {1'b0, p_start} + (ABS_BITS+1)'(p_offs);

    // remainder stays below span, so the doubled value fits one extra bit
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, r_span});

    always_comb begin
        if (r_span == '0) begin
            alpha = '0;
        end else if (r_sat) begin
            alpha = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
        end else begin
            alpha = {1'b0, r_quo};
        end
    end

    assign o_pop    = (r_state == B_IDLE) && i_q_valid;
    assign load_out = (r_state == B_DONE) && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if ((p_span == '0) || (p_offs >= p_span)) begin
                        n_state = B_DONE;
                    end else begin
                        n_state = B_DIV;
                    end
                end
            end
            B_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (load_out) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_head <= p_head;
            r_offs <= p_offs;
            r_span <= p_span;
            r_abs  <= abs_sum[ABS_BITS] ? {ABS_BITS{1'b1}} : abs_sum[ABS_BITS-1:0];
            r_rem  <= p_offs;
            r_quo  <= '0;
            r_sat  <= (p_offs >= p_span);
            r_cnt  <= CNT_W'(ALPHA_FRAC_BITS);
        end else if (r_state == B_DIV) begin
            r_rem <= rem_ge ? SPAN_BITS'(rem2 - {1'b0, r_span}) : rem2[SPAN_BITS-1:0];
            r_quo <= {r_quo[ALPHA_FRAC_BITS-2:0], rem_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (load_out) begin
            r_out <= {alpha, r_span, r_abs, r_offs, r_head};
        end
    end

    a_alpha_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out[OUT_W-1 -: AW] <= {1'b1, {ALPHA_FRAC_BITS{1'b0}}}))
        else $error("alpha above saturation value");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_rem < r_span))
        else $error("divider remainder not below span");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> ((r_state == B_DIV) || (r_state == B_DONE)))
        else $error("popped request did not start work");

endmodule

`default_nettype wire

>>> rtl/core/lidar_point_gate_filter_core.sv
// The gating front steps each point through IDLE, SQR and CHK and takes no new
// point until it is back in IDLE; a passing point waits in CHK while the queue
// is full. The back end goes to DONE for zero span or a saturated alpha, else
// via the bit-serial alpha divider in DIV, and pops its next point only from IDLE.
// Reset (synchronous, active low) clears the point phase, queue, control
// state and output valid, and loads the register reset values.
// ----------------------------------------------------------------------------
// lidar_point_gate_filter_core
// Range, decimation and tag gate for lidar points with frame timing outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_gate_filter_core #(
    parameter int COORD_BITS      = lpgf_pkg::COORD_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = lpgf_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  s_axis_tvalid,
    output logic s_axis_tready,
    // x_mm, y_mm, z_mm, reflectivity, scan_line, tag, offset_ns, span_ns,
    // frame_start_ns, zero fill
    input  wire  [((3*COORD_BITS+151+7)/8)*8-1:0] s_axis_tdata,
    // first_point, coords_finite
    input  wire  [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  wire  m_axis_tready,
    // out_x_mm, out_y_mm, out_z_mm, intensity, ring, relative_ns, absolute_ns,
    // frame_span_ns, alpha, zero fill
    output logic [((3*COORD_BITS+ALPHA_FRAC_BITS+144+7)/8)*8-1:0] m_axis_tdata,
    input  wire  i_cfg_valid,
    output logic o_cfg_ready,
    input  wire  [lpgf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [lpgf_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import lpgf_pkg::*;

    localparam int OUT_N = 3 * COORD_BITS + ALPHA_FRAC_BITS + 144;
    localparam int OUT_W = ((OUT_N + 7) / 8) * 8;
    localparam int PAY_W = 3 * COORD_BITS + 2 * BYTE_BITS + OFFS_BITS + SPAN_BITS + ABS_BITS;
    localparam int C3    = 3 * COORD_BITS;

    t_cfg             r_cfg;
    logic             q_push, q_ready, q_valid, q_pop;
    logic [PAY_W-1:0] f_payload, q_payload;
    logic [OUT_N-1:0] b_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decimation   <= DEC_RESET;
            r_cfg.blind_mm     <= BLIND_RESET;
            r_cfg.max_range_mm <= MAX_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DECIMATION: r_cfg.decimation   <= i_cfg_data[DEC_BITS-1:0];
                CFG_BLIND_MM:   r_cfg.blind_mm     <= i_cfg_data[RANGE_BITS-1:0];
                CFG_MAX_MM:     r_cfg.max_range_mm <= i_cfg_data[RANGE_BITS-1:0];
                default: begin
                    // write beyond the register list: drop
                end
            endcase
        end
    end

    lpgf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_first   (s_axis_tuser[0]),
        .i_finite  (s_axis_tuser[1]),
        .i_x       (s_axis_tdata[0 +: COORD_BITS]),
        .i_y       (s_axis_tdata[COORD_BITS +: COORD_BITS]),
        .i_z       (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_refl    (s_axis_tdata[C3 +: BYTE_BITS]),
        .i_line    (s_axis_tdata[C3+8 +: BYTE_BITS]),
        .i_tag     (s_axis_tdata[C3+16 +: BYTE_BITS]),
        .i_offs    (s_axis_tdata[C3+24 +: OFFS_BITS]),
        .i_span    (s_axis_tdata[C3+56 +: SPAN_BITS]),
        .i_start   (s_axis_tdata[C3+88 +: ABS_BITS]),
        .o_push    (q_push),
        .i_q_ready (q_ready),
        .o_payload (f_payload)
    );

    lpgf_queue #(
        .WIDTH (PAY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .i_data  (f_payload),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_payload)
    );

    lpgf_back #(
        .COORD_BITS      (COORD_BITS),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (q_pop),
        .i_payload (q_payload),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (b_data)
    );

    assign m_axis_tdata = OUT_W'(b_data);

endmodule

`default_nettype wire
